// ----- rtl/hcbp_pkg.sv -----
// Package for the prefix-code byte packer: field widths, item codes,
// queue entry and status types and the back-end state type. No dependencies.
`default_nettype none

package hcbp_pkg;

  localparam int PATTERN_BITS = 32;
  localparam int LENGTH_BITS  = 6;
  localparam int SYMBOL_BITS  = 7;
  localparam int FUNC_BITS    = 2;
  localparam int BYTE_BITS    = 8;
  localparam int PENDING_BITS = 7;
  localparam int COUNT_BITS   = 3;
  localparam int ACC_BITS     = PENDING_BITS + PATTERN_BITS;
  localparam int TOTAL_BITS   = 6;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_AW     = 2;

  localparam logic [FUNC_BITS-1:0] FUNC_LOAD   = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_ENCODE = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_FLUSH  = 2'd2;

  typedef struct packed {
    logic                    flush;
    logic [PATTERN_BITS-1:0] pattern;
    logic [LENGTH_BITS-1:0]  length;
  } hcbp_op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } hcbp_qstat_t;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } hcbp_back_state_t;

endpackage

`default_nettype wire

// ----- rtl/hcbp_if.sv -----
// Handshake interfaces for the item input and the packed byte output.
// Depends on hcbp_pkg for the field widths.
`default_nettype none

interface hcbp_in_if;
  import hcbp_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [FUNC_BITS-1:0]    func;
  logic [SYMBOL_BITS-1:0]  symbol;
  logic [PATTERN_BITS-1:0] code_pattern;
  logic [LENGTH_BITS-1:0]  code_length;
  modport source (output valid, func, symbol, code_pattern, code_length, input ready);
  modport sink   (input valid, func, symbol, code_pattern, code_length, output ready);
endinterface

interface hcbp_out_if;
  import hcbp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [BYTE_BITS-1:0] packed_byte;
  logic                 last_of_run;
  modport source (output valid, packed_byte, last_of_run, input ready);
  modport sink   (input valid, packed_byte, last_of_run, output ready);
endinterface

`default_nettype wire

// ----- rtl/hcbp_front.sv -----
// Front end: accepts items, holds the code table memory and turns encode and
// flush items into queue entries. Depends on hcbp_pkg and hcbp_if.
`default_nettype none

module hcbp_front #(
  parameter int SYMBOL_COUNT = 128,
  parameter int MAX_CODE_LEN = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  hcbp_in_if.sink                item,
  input  wire hcbp_pkg::hcbp_qstat_t qstat,
  output logic                   push,
  output hcbp_pkg::hcbp_op_t     push_op
);
  import hcbp_pkg::*;

  localparam int AW        = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int LEN_LIMIT = (MAX_CODE_LEN < PATTERN_BITS) ? MAX_CODE_LEN : PATTERN_BITS;

  logic [PATTERN_BITS-1:0] pattern_mem [SYMBOL_COUNT];
  logic [LENGTH_BITS-1:0]  length_mem  [SYMBOL_COUNT];

  logic                    staged;
  logic                    staged_flush;
  logic [PATTERN_BITS-1:0] rd_pattern;
  logic [LENGTH_BITS-1:0]  rd_length;

  logic [8:0]    sym_ext;
  logic          sym_ok;
  logic [AW-1:0] addr;
  logic          accept;
  logic          take;

  assign sym_ext    = {2'b00, item.symbol};
  assign sym_ok     = sym_ext < 9'(SYMBOL_COUNT);
  assign addr       = sym_ext[AW-1:0];
  assign item.ready = !staged || !qstat.full;
  assign accept     = item.valid && item.ready;
  assign take       = accept && ((item.func == FUNC_ENCODE && sym_ok) ||
                                 item.func == FUNC_FLUSH);
  assign push       = staged && !qstat.full;

  always_comb begin
    push_op.flush   = staged_flush;
    push_op.pattern = rd_pattern;
    if (rd_length > LENGTH_BITS'(LEN_LIMIT)) begin
      push_op.length = LENGTH_BITS'(LEN_LIMIT);
    end else begin
      push_op.length = rd_length;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.func == FUNC_LOAD && sym_ok) begin
      pattern_mem[addr] <= item.code_pattern;
      length_mem[addr]  <= item.code_length;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rd_pattern   <= pattern_mem[addr];
      rd_length    <= length_mem[addr];
      staged_flush <= (item.func == FUNC_FLUSH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      staged <= 1'b0;
    end else if (take) begin
      staged <= 1'b1;
    end else if (push) begin
      staged <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hcbp_queue.sv -----
// Short queue of pending operations between the front and back ends.
// Depends on hcbp_pkg.
`default_nettype none

module hcbp_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire hcbp_pkg::hcbp_op_t  push_op,
  input  wire logic                pop,
  output hcbp_pkg::hcbp_op_t       pop_op,
  output hcbp_pkg::hcbp_qstat_t    qstat
);
  import hcbp_pkg::*;

  hcbp_op_t            entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   fill;

  assign qstat.full  = (fill == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign qstat.empty = (fill == '0);
  assign pop_op      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hcbp_back.sv -----
// Back end: appends codes to the bit accumulator, emits completed bytes one
// per beat through an output register, and pads on flush. Depends on hcbp_pkg.
`default_nettype none

module hcbp_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire hcbp_pkg::hcbp_qstat_t qstat,
  input  wire hcbp_pkg::hcbp_op_t    op,
  output logic                       pop,
  hcbp_out_if.source                 result
);
  import hcbp_pkg::*;

  hcbp_back_state_t state;
  hcbp_back_state_t state_next;

  logic [PENDING_BITS-1:0] pending;
  logic [COUNT_BITS-1:0]   count;
  logic [ACC_BITS-1:0]     acc;
  logic [TOTAL_BITS-1:0]   total;
  logic                    out_valid;
  logic [BYTE_BITS-1:0]    out_byte;
  logic                    out_last;

  logic                    out_free;
  logic [COUNT_BITS-1:0]   pad;
  logic [LENGTH_BITS-1:0]  len_eff;
  logic [PATTERN_BITS:0]   mask_wide;
  logic [PATTERN_BITS-1:0] pat_eff;
  logic [ACC_BITS-1:0]     acc_new;
  logic [TOTAL_BITS-1:0]   total_new;
  logic [TOTAL_BITS-1:0]   total_rem;
  logic [TOTAL_BITS-1:0]   shift;
  logic [BYTE_BITS-1:0]    byte_now;
  logic [BYTE_BITS-1:0]    rem_mask;
  logic                    rem_small;

  assign result.valid       = out_valid;
  assign result.packed_byte = out_byte;
  assign result.last_of_run = out_last;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (pop && total_new >= TOTAL_BITS'(BYTE_BITS)) begin
          state_next = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (out_free && rem_small) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    out_free  = !out_valid || result.ready;
    pop       = (state == BK_IDLE) && !qstat.empty;
    pad       = COUNT_BITS'(4'(BYTE_BITS) - {1'b0, count});
    len_eff   = op.flush ? {3'b000, pad} : op.length;
    mask_wide = ((PATTERN_BITS+1)'(1) << len_eff) - (PATTERN_BITS+1)'(1);
    pat_eff   = op.flush ? '0 : (op.pattern & mask_wide[PATTERN_BITS-1:0]);
    acc_new   = ({{PATTERN_BITS{1'b0}}, pending} << len_eff) |
                {{PENDING_BITS{1'b0}}, pat_eff};
    total_new = TOTAL_BITS'(count) + len_eff;
    shift     = total - TOTAL_BITS'(BYTE_BITS);
    total_rem = shift;
    byte_now  = BYTE_BITS'(acc >> shift);
    rem_small = total_rem < TOTAL_BITS'(BYTE_BITS);
    rem_mask  = (BYTE_BITS'(1) << total_rem[COUNT_BITS-1:0]) - BYTE_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == BK_IDLE && pop) begin
        if (total_new >= TOTAL_BITS'(BYTE_BITS)) begin
          acc   <= acc_new;
          total <= total_new;
        end else begin
          pending <= acc_new[PENDING_BITS-1:0];
          count   <= total_new[COUNT_BITS-1:0];
        end
      end
      if (state == BK_EMIT && out_free) begin
        out_valid <= 1'b1;
        out_byte  <= byte_now;
        out_last  <= rem_small;
        total     <= total_rem;
        if (rem_small) begin
          pending <= acc[PENDING_BITS-1:0] & rem_mask[PENDING_BITS-1:0];
          count   <= total_rem[COUNT_BITS-1:0];
        end
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/huffman_code_byte_packer_top.sv -----
// The first byte of an encode or flush item passes through the staging register, the queue,
// the accumulator and the output register. The back end takes an operation from the queue
// and then emits each byte it completes, taking no new operation until the item's last byte
// is in the output register. The front end accepts one item a cycle while its staging register
// is empty or the queue has room. Reset clears the pending bits, the queue and the output
// valid flag; the code table is not cleared and holds no meaning until loaded.
`default_nettype none

module huffman_code_byte_packer_top #(
  parameter int SYMBOL_COUNT = 128,
  parameter int MAX_CODE_LEN = 32
) (
  input wire logic   clk,
  input wire logic   rst,
  hcbp_in_if.sink    item,
  hcbp_out_if.source result
);
  import hcbp_pkg::*;

  hcbp_qstat_t qstat;
  hcbp_op_t    push_op;
  hcbp_op_t    pop_op;
  logic        push;
  logic        pop;

  hcbp_front #(
    .SYMBOL_COUNT(SYMBOL_COUNT),
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .qstat  (qstat),
    .push   (push),
    .push_op(push_op)
  );

  hcbp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .push_op(push_op),
    .pop    (pop),
    .pop_op (pop_op),
    .qstat  (qstat)
  );

  hcbp_back u_back (
    .clk   (clk),
    .rst   (rst),
    .qstat (qstat),
    .op    (pop_op),
    .pop   (pop),
    .result(result)
  );

endmodule

`default_nettype wire

// ----- rtl/hcbp_checker.sv -----
// Port-level checks for the byte packer, attached to the top level by bind.
// Depends on hcbp_pkg and on the top level's interface ports.
`default_nettype none

module hcbp_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       item_ready,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic [7:0] res_byte,
  input wire logic       res_last
);
  import hcbp_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("output beat shown straight after reset");

  a_reset_ready: assert property (@(posedge clk) rst |=> item_ready)
    else $error("input not ready straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_byte) && $stable(res_last))
    else $error("stalled output beat changed");

endmodule

bind huffman_code_byte_packer_top hcbp_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .item_ready(item.ready),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_byte  (result.packed_byte),
  .res_last  (result.last_of_run)
);

`default_nettype wire
